/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the parser unit.
// ----------------------------------------------------------------------------
// Each macro expects a signal named clock and a signal named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ACFRP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition is never seen outside reset.
`define ACFRP_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

/* hw/rtl/acfrp_pkg.sv */
// ----------------------------------------------------------------------------
// acfrp_pkg
// Types, widths and character codes of the ASCII CAN frame request parser.
// ----------------------------------------------------------------------------
package acfrp_pkg;

   localparam int RX_CHAR_W   = 8;
   localparam int STAGE_W     = 4;
   localparam int IDENT_W     = 12;
   localparam int LENGTH_W    = 4;
   localparam int PAYLOAD_W   = 64;
   localparam int PERIOD_W    = 16;
   localparam int ACC_W       = 19;
   localparam int POS_W       = 2;
   localparam int KIND_W      = 2;

   localparam logic [ACC_W-1:0]  IDENT_LIMIT = 19'd2048;
   localparam logic [KIND_W-1:0] KIND_ONCE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCHED  = 2'd2;

   localparam logic [RX_CHAR_W-1:0] CHAR_ZERO_OFS  = 8'd48;
   localparam logic [RX_CHAR_W-1:0] CHAR_UPPER_OFS = 8'd55;
   localparam logic [RX_CHAR_W-1:0] CHAR_LOWER_OFS = 8'd87;

   typedef enum logic [STAGE_W-1:0] {
      ST_MODE    = 4'd0,
      ST_ID      = 4'd1,
      ST_LEN     = 4'd2,
      ST_BYTE1   = 4'd3,
      ST_BYTE2   = 4'd4,
      ST_BYTE3   = 4'd5,
      ST_BYTE4   = 4'd6,
      ST_BYTE5   = 4'd7,
      ST_BYTE6   = 4'd8,
      ST_BYTE7   = 4'd9,
      ST_BYTE8   = 4'd10,
      ST_PERIOD  = 4'd11,
      ST_SUMMARY = 4'd12,
      ST_ERROR   = 4'd13
   } stage_type;

   // Hex digit value; anything that is not a hex digit counts as zero.
   function automatic logic [3:0] hex_value(input logic [RX_CHAR_W-1:0] ch);
      logic [RX_CHAR_W-1:0] v;
      begin
         if (ch inside {[8'h30:8'h39]}) begin
            v = ch - CHAR_ZERO_OFS;
         end else if (ch inside {[8'h41:8'h46]}) begin
            v = ch - CHAR_UPPER_OFS;
         end else if (ch inside {[8'h61:8'h66]}) begin
            v = ch - CHAR_LOWER_OFS;
         end else begin
            v = '0;
         end
         return v[3:0];
      end
   endfunction

   // Decimal digit value, wrapped to eight bits for non-digits.
   function automatic logic [RX_CHAR_W-1:0] dec_value(input logic [RX_CHAR_W-1:0] ch);
      return ch - CHAR_ZERO_OFS;
   endfunction

endpackage

/* hw/rtl/acfrp_if.sv */
// ----------------------------------------------------------------------------
// acfrp_req_if / acfrp_rsp_if
// Valid/ready channels carrying received characters and parser results.
// ----------------------------------------------------------------------------
interface acfrp_req_if import acfrp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [RX_CHAR_W-1:0] rx_char;

   modport source (output valid, output rx_char, input ready);
   modport sink   (input valid, input rx_char, output ready);
endinterface

interface acfrp_rsp_if import acfrp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STAGE_W-1:0]   prompt_stage;
   logic                 prompt_due;
   logic                 issue_valid;
   logic                 issue_schedule;
   logic [IDENT_W-1:0]   frame_ident;
   logic [LENGTH_W-1:0]  frame_length;
   logic [PAYLOAD_W-1:0] frame_payload;
   logic [PERIOD_W-1:0]  frame_period;

   modport source (output valid, output prompt_stage, output prompt_due,
                   output issue_valid, output issue_schedule, output frame_ident,
                   output frame_length, output frame_payload, output frame_period,
                   input ready);
   modport sink   (input valid, input prompt_stage, input prompt_due,
                   input issue_valid, input issue_schedule, input frame_ident,
                   input frame_length, input frame_payload, input frame_period,
                   output ready);
endinterface

/* hw/rtl/ascii_can_frame_request_parser_unit.sv */
// ----------------------------------------------------------------------------
// ascii_can_frame_request_parser_unit
// Collects a CAN frame request from a stream of received ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one received character per request (rx_char). Every
//   request yields exactly one result on rsp_chan: the stage reached, a flag
//   that a new prompt is due and, when the summary stage is left, the issued
//   frame (mode, ident, length, payload, period); frame fields are zero when
//   no frame is issued.
//   A request is captured in an input register, decoded against the parser
//   state and written to the result register, from which its result is
//   offered. Throughput is one request per cycle while rsp_chan does not
//   stall: the digit accumulate and the group checks are a single shift-add
//   and compare between the two registers. When rsp_chan stalls, the result
//   register holds and the input register still takes one more request;
//   req_chan.ready then falls until the result is taken.
//   A synchronous reset returns the parser to the mode stage and empties
//   both registers. Payload bytes are cleared whenever a length is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_can_frame_request_parser_unit import acfrp_pkg::*; #(
   parameter int MAX_PAYLOAD_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   acfrp_req_if.sink   req_chan,
   acfrp_rsp_if.source rsp_chan
);

   // input register
   logic                 s1_valid_ff;
   logic [RX_CHAR_W-1:0] s1_char_ff;
   logic                 s1_advance;
   logic                 s1_fire;

   // parser state
   stage_type            stage_ff, stage_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [IDENT_W-1:0]   ident_ff, ident_in;
   logic [LENGTH_W-1:0]  length_ff, length_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [7:0]           payload_ff [MAX_PAYLOAD_BYTES];
   logic [7:0]           payload_in [MAX_PAYLOAD_BYTES];

   // result register
   logic                 rsp_valid_ff;
   logic [STAGE_W-1:0]   rsp_stage_ff, rsp_stage_in;
   logic                 rsp_due_ff, rsp_due_in;
   logic                 rsp_issue_ff, rsp_issue_in;
   logic                 rsp_sched_ff, rsp_sched_in;
   logic [IDENT_W-1:0]   rsp_ident_ff, rsp_ident_in;
   logic [LENGTH_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic [PERIOD_W-1:0]  rsp_period_ff, rsp_period_in;

   // decode
   logic                 hex_mode;
   logic [2:0]           group_len;
   logic                 group_done;
   logic [ACC_W-1:0]     acc_scaled;
   logic [ACC_W-1:0]     acc_next;
   logic [LENGTH_W-1:0]  byte_idx;
   logic [LENGTH_W-1:0]  byte_num;
   logic                 issue_now;

   assign s1_advance    = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire       = s1_valid_ff && s1_advance;
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   // Group size and digit base of the current stage.
   always_comb begin
      hex_mode  = 1'b0;
      group_len = 3'd1;
      case (stage_ff)
         ST_ID: begin
            hex_mode  = 1'b1;
            group_len = 3'd3;
         end
         ST_BYTE1, ST_BYTE2, ST_BYTE3, ST_BYTE4,
         ST_BYTE5, ST_BYTE6, ST_BYTE7, ST_BYTE8: begin
            hex_mode  = 1'b1;
            group_len = 3'd2;
         end
         ST_PERIOD: begin
            group_len = 3'd4;
         end
         default: begin
            group_len = 3'd1;
         end
      endcase
   end

   assign acc_scaled = hex_mode ? {acc_ff[ACC_W-5:0], 4'h0}
                                : ({acc_ff[ACC_W-4:0], 3'b000} + {acc_ff[ACC_W-2:0], 1'b0});
   assign acc_next   = acc_scaled + (hex_mode ? ACC_W'(hex_value(s1_char_ff))
                                              : ACC_W'(dec_value(s1_char_ff)));
   assign group_done = ({1'b0, pos_ff} + 3'd1) >= group_len;
   assign byte_idx   = stage_ff - ST_BYTE1;
   assign byte_num   = byte_idx + 4'd1;

   // Next state.
   always_comb begin
      stage_in  = stage_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      kind_in   = kind_ff;
      ident_in  = ident_ff;
      length_in = length_ff;
      period_in = period_ff;
      payload_in = payload_ff;
      issue_now = 1'b0;
      if (!group_done) begin
         pos_in = pos_ff + 2'd1;
         acc_in = acc_next;
      end else begin
         pos_in = '0;
         acc_in = '0;
         case (stage_ff)
            ST_MODE: begin
               if (acc_next == ACC_W'(KIND_ONCE) || acc_next == ACC_W'(KIND_SCHED)) begin
                  kind_in  = acc_next[KIND_W-1:0];
                  stage_in = ST_ID;
               end else begin
                  stage_in = ST_ERROR;
               end
            end
            ST_ID: begin
               if (acc_next <= IDENT_LIMIT) begin
                  ident_in = acc_next[IDENT_W-1:0];
                  stage_in = ST_LEN;
               end else begin
                  stage_in = ST_ERROR;
               end
            end
            ST_LEN: begin
               if (acc_next != '0 && acc_next <= ACC_W'(MAX_PAYLOAD_BYTES)) begin
                  for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
                     payload_in[i] = '0;
                  end
                  length_in = acc_next[LENGTH_W-1:0];
                  stage_in  = ST_BYTE1;
               end else begin
                  stage_in = ST_ERROR;
               end
            end
            ST_BYTE1, ST_BYTE2, ST_BYTE3, ST_BYTE4,
            ST_BYTE5, ST_BYTE6, ST_BYTE7, ST_BYTE8: begin
               for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
                  if (byte_idx == LENGTH_W'(i)) begin
                     payload_in[i] = acc_next[7:0];
                  end
               end
               if (byte_num < length_ff) begin
                  stage_in = stage_type'(stage_ff + 4'd1);
               end else if (kind_ff == KIND_ONCE) begin
                  stage_in = ST_SUMMARY;
               end else begin
                  stage_in = ST_PERIOD;
               end
            end
            ST_PERIOD: begin
               if (acc_next != '0) begin
                  period_in = acc_next[PERIOD_W-1:0];
                  stage_in  = ST_SUMMARY;
               end else begin
                  stage_in = ST_ERROR;
               end
            end
            ST_SUMMARY: begin
               issue_now = 1'b1;
               stage_in  = ST_MODE;
            end
            default: begin
               // error stage and unused codes: back to mode
               stage_in = ST_MODE;
            end
         endcase
      end
   end

   // Result fields.
   always_comb begin
      rsp_stage_in   = stage_in;
      rsp_due_in     = group_done;
      rsp_issue_in   = issue_now;
      rsp_sched_in   = 1'b0;
      rsp_ident_in   = '0;
      rsp_length_in  = '0;
      rsp_payload_in = '0;
      rsp_period_in  = '0;
      if (issue_now) begin
         rsp_sched_in  = (kind_ff != KIND_ONCE);
         rsp_ident_in  = ident_ff;
         rsp_length_in = length_ff;
         for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
            if (LENGTH_W'(i) < length_ff) begin
               rsp_payload_in[8*i +: 8] = payload_ff[i];
            end
         end
         if (kind_ff != KIND_ONCE) begin
            rsp_period_in = period_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         s1_char_ff <= req_chan.rx_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= ST_MODE;
         pos_ff    <= '0;
         acc_ff    <= '0;
         kind_ff   <= '0;
         ident_ff  <= '0;
         length_ff <= '0;
         period_ff <= '0;
      end else if (s1_fire) begin
         stage_ff  <= stage_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         kind_ff   <= kind_in;
         ident_ff  <= ident_in;
         length_ff <= length_in;
         period_ff <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         payload_ff <= payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_stage_ff   <= rsp_stage_in;
         rsp_due_ff     <= rsp_due_in;
         rsp_issue_ff   <= rsp_issue_in;
         rsp_sched_ff   <= rsp_sched_in;
         rsp_ident_ff   <= rsp_ident_in;
         rsp_length_ff  <= rsp_length_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_period_ff  <= rsp_period_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.prompt_stage   = rsp_stage_ff;
   assign rsp_chan.prompt_due     = rsp_due_ff;
   assign rsp_chan.issue_valid    = rsp_issue_ff;
   assign rsp_chan.issue_schedule = rsp_sched_ff;
   assign rsp_chan.frame_ident    = rsp_ident_ff;
   assign rsp_chan.frame_length   = rsp_length_ff;
   assign rsp_chan.frame_payload  = rsp_payload_ff;
   assign rsp_chan.frame_period   = rsp_period_ff;

   // An issued frame always returns the parser to the mode stage.
   `ACFRP_ASSERT(a_issue_to_mode, rsp_valid_ff && rsp_issue_ff |-> rsp_stage_ff == ST_MODE && rsp_due_ff, "issue without return to mode stage")
   // Only multi-character groups keep a nonzero character position.
   `ACFRP_ASSERT(a_pos_group, pos_ff != '0 |-> stage_ff == ST_ID || stage_ff == ST_PERIOD || (stage_ff >= ST_BYTE1 && stage_ff <= ST_BYTE8), "character position outside a digit group")
   // Byte stages only run with an accepted length.
   `ACFRP_ASSERT(a_len_range, stage_ff >= ST_BYTE1 && stage_ff <= ST_BYTE8 |-> length_ff != '0 && length_ff <= LENGTH_W'(MAX_PAYLOAD_BYTES) && byte_idx < length_ff, "byte stage beyond accepted length")
   // A stalled input register keeps its request.
   `ACFRP_ASSERT(a_s1_hold, s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_char_ff), "input register lost a stalled request")
   // Send-once results carry no period.
   `ACFRP_NEVER(n_once_period, rsp_valid_ff && !rsp_sched_ff && rsp_period_ff != '0, "period on a send-once result")

endmodule

/* tb/ascii_can_frame_request_parser_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_frame_request_parser_checker
// Watches both channels of the parser, runs a cycle-free model of the
// character parser on every accepted request and compares each accepted
// result, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module ascii_can_frame_request_parser_checker import acfrp_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   acfrp_req_if  req_mon,
   acfrp_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    outstanding
);

   localparam int MAX_BYTES   = 8;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [STAGE_W-1:0]   stage;
      logic                 due;
      logic                 issue;
      logic                 sched;
      logic [IDENT_W-1:0]   ident;
      logic [LENGTH_W-1:0]  len;
      logic [PAYLOAD_W-1:0] payload;
      logic [PERIOD_W-1:0]  period;
   } parser_result_type;

   stage_type           parse_stage;
   logic [POS_W-1:0]    digit_pos;
   logic [ACC_W-1:0]    digit_acc;
   logic [KIND_W-1:0]   kind_q;
   logic [IDENT_W-1:0]  ident_q;
   logic [LENGTH_W-1:0] len_q;
   logic [7:0]          payload_q [MAX_BYTES];
   logic [PERIOD_W-1:0] period_q;

   parser_result_type   frame_results_q [$];
   int                  reported;

   function automatic logic [3:0] nibble_of(input logic [RX_CHAR_W-1:0] ch);
      logic [RX_CHAR_W-1:0] v;
      v = 8'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         v = ch - CHAR_ZERO_OFS;
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         v = ch - CHAR_UPPER_OFS;
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         v = ch - CHAR_LOWER_OFS;
      end
      return v[3:0];
   endfunction

   task automatic clear_parser();
      parse_stage = ST_MODE;
      digit_pos   = '0;
      digit_acc   = '0;
      kind_q      = '0;
      ident_q     = '0;
      len_q       = '0;
      period_q    = '0;
      for (int i = 0; i < MAX_BYTES; i++) payload_q[i] = 8'd0;
   endtask

   // Advance the parser by one character and form the result it gives.
   task automatic parse_char(input logic [RX_CHAR_W-1:0] ch, output parser_result_type res);
      int                   group;
      int                   num;
      logic                 hex_group;
      logic                 sched;
      logic [RX_CHAR_W-1:0] dec_digit;
      logic [31:0]          sum;
      logic [ACC_W-1:0]     acc;
      res       = '0;
      group     = 1;
      hex_group = 1'b0;
      if (parse_stage == ST_ID) begin
         group     = 3;
         hex_group = 1'b1;
      end else if (parse_stage >= ST_BYTE1 && parse_stage <= ST_BYTE8) begin
         group     = 2;
         hex_group = 1'b1;
      end else if (parse_stage == ST_PERIOD) begin
         group = 4;
      end
      dec_digit = ch - CHAR_ZERO_OFS;
      if (hex_group) sum = 32'(digit_acc) * 32'd16 + 32'(nibble_of(ch));
      else           sum = 32'(digit_acc) * 32'd10 + 32'(dec_digit);
      acc = sum[ACC_W-1:0];

      if (int'(digit_pos) + 1 < group) begin
         digit_pos = digit_pos + 1'b1;
         digit_acc = acc;
      end else begin
         digit_pos = '0;
         digit_acc = '0;
         res.due   = 1'b1;
         case (parse_stage)
            ST_MODE: begin
               if (acc == 19'(KIND_ONCE) || acc == 19'(KIND_SCHED)) begin
                  kind_q      = acc[KIND_W-1:0];
                  parse_stage = ST_ID;
               end else begin
                  parse_stage = ST_ERROR;
               end
            end
            ST_ID: begin
               if (acc <= IDENT_LIMIT) begin
                  ident_q     = acc[IDENT_W-1:0];
                  parse_stage = ST_LEN;
               end else begin
                  parse_stage = ST_ERROR;
               end
            end
            ST_LEN: begin
               if (acc >= 19'd1 && acc <= 19'(MAX_BYTES)) begin
                  for (int i = 0; i < MAX_BYTES; i++) payload_q[i] = 8'd0;
                  len_q       = acc[LENGTH_W-1:0];
                  parse_stage = ST_BYTE1;
               end else begin
                  parse_stage = ST_ERROR;
               end
            end
            ST_BYTE1, ST_BYTE2, ST_BYTE3, ST_BYTE4,
            ST_BYTE5, ST_BYTE6, ST_BYTE7, ST_BYTE8: begin
               num = int'(parse_stage) - int'(ST_BYTE1) + 1;
               payload_q[num-1] = acc[7:0];
               if (num < int'(len_q)) parse_stage = stage_type'(parse_stage + 1);
               else if (kind_q == KIND_ONCE) parse_stage = ST_SUMMARY;
               else parse_stage = ST_PERIOD;
            end
            ST_PERIOD: begin
               // a nonzero sum passes even when its low 16 bits are zero
               if (acc != '0) begin
                  period_q    = acc[PERIOD_W-1:0];
                  parse_stage = ST_SUMMARY;
               end else begin
                  parse_stage = ST_ERROR;
               end
            end
            ST_SUMMARY: begin
               res.issue   = 1'b1;
               parse_stage = ST_MODE;
            end
            default: begin
               parse_stage = ST_MODE;
            end
         endcase
      end

      res.stage = parse_stage;
      if (res.issue) begin
         sched     = (kind_q != KIND_ONCE);
         res.sched = sched;
         res.ident = ident_q;
         res.len   = len_q;
         for (int i = 0; i < MAX_BYTES; i++) begin
            if (i < int'(len_q)) res.payload[8*i +: 8] = payload_q[i];
         end
         res.period = sched ? period_q : '0;
      end
   endtask

   task automatic report_mismatch(input string what, input parser_result_type exp_r,
                                  input parser_result_type act_r);
      mismatch_count++;
      if (reported < REPORT_MAX) begin
         reported++;
         $display("[%0t] mismatch: %s", $realtime, what);
         $display("   expected stage=%0d due=%b issue=%b sched=%b id=%h len=%0d data=%h per=%h",
                  exp_r.stage, exp_r.due, exp_r.issue, exp_r.sched, exp_r.ident, exp_r.len,
                  exp_r.payload, exp_r.period);
         $display("   actual   stage=%0d due=%b issue=%b sched=%b id=%h len=%0d data=%h per=%h",
                  act_r.stage, act_r.due, act_r.issue, act_r.sched, act_r.ident, act_r.len,
                  act_r.payload, act_r.period);
      end
   endtask

   always @(posedge clock) begin : monitor
      parser_result_type predicted;
      parser_result_type oldest;
      parser_result_type seen;
      if (reset) begin
         clear_parser();
         frame_results_q.delete();
         mismatch_count = 0;
         outstanding    = 0;
         reported       = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            parse_char(req_mon.rx_char, predicted);
            frame_results_q.push_back(predicted);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.prompt_stage, rsp_mon.prompt_due, rsp_mon.issue_valid,
                    rsp_mon.issue_schedule, rsp_mon.frame_ident, rsp_mon.frame_length,
                    rsp_mon.frame_payload, rsp_mon.frame_period};
            if (frame_results_q.size() == 0) begin
               report_mismatch("result with no request outstanding", '0, seen);
            end else begin
               oldest = frame_results_q.pop_front();
               if (seen !== oldest) report_mismatch("wrong result field", oldest, seen);
            end
         end
         outstanding = frame_results_q.size();
      end
   end

endmodule

/* tb/ascii_can_frame_request_parser_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_can_frame_request_parser_unit_tb
// Feeds the parser directed character strings, then random frame requests (mostly
// well formed, some rejected at any group but the bytes), with random gaps on
// the request side and random stalls on the result side. A checker beside the
// block predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module ascii_can_frame_request_parser_unit_tb import acfrp_pkg::*; ();

   localparam int CHAR_TARGET = 450;

   logic clock;
   logic reset;

   int   chars_sent  = 0;
   int   calm_left   = 0;
   int   sink_calm   = 0;
   int   sink_stall  = 0;
   int   mismatch_count;
   int   outstanding;

   acfrp_req_if req_chan ();
   acfrp_rsp_if rsp_chan ();

   ascii_can_frame_request_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ascii_can_frame_request_parser_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #10 clock = ~clock;

   // Mostly short gaps, now and then a long one, and calm stretches with none.
   function automatic int source_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (roll < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Hex digit in random case; a zero digit may come as a non-hex character.
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit allow_junk);
      if (allow_junk && nib == 4'd0 && $urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1)) return 8'($urandom_range(8'h67, 8'hFF));
         return 8'($urandom_range(8'h00, 8'h2F));
      end
      if (nib < 4'd10) return CHAR_ZERO_OFS + 8'(nib);
      if ($urandom_range(0, 1)) return CHAR_UPPER_OFS + 8'(nib);
      return CHAR_LOWER_OFS + 8'(nib);
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic push_char(input logic [7:0] ch);
      int gap;
      gap = source_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_char <= ch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   // One frame request; some are broken at a chosen group and then recovered.
   task automatic send_frame_request();
      int          shape;
      int          len;
      bit          sched;
      bit          any_nonzero;
      logic [7:0]  ch;
      logic [11:0] ident;
      shape = $urandom_range(0, 99);
      if (shape >= 70 && shape < 78) begin
         do ch = 8'($urandom_range(0, 255));
         while (ch == CHAR_ZERO_OFS + 8'd1 || ch == CHAR_ZERO_OFS + 8'd2);
         push_char(ch);
         push_char(8'($urandom_range(0, 255)));
         return;
      end
      sched = $urandom_range(0, 1);
      push_char(CHAR_ZERO_OFS + (sched ? 8'd2 : 8'd1));

      if (shape >= 78 && shape < 85) begin
         ident = 12'($urandom_range(2049, 4095));
         for (int i = 2; i >= 0; i--) push_char(hex_char(ident[4*i +: 4], 1'b0));
         push_char(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 9))
         0:       ident = 12'd2048;
         1:       ident = 12'd0;
         default: ident = 12'($urandom_range(0, 2048));
      endcase
      for (int i = 2; i >= 0; i--) push_char(hex_char(ident[4*i +: 4], 1'b1));

      if (shape >= 85 && shape < 93) begin
         do ch = 8'($urandom_range(0, 255));
         while (ch >= CHAR_ZERO_OFS + 8'd1 && ch <= CHAR_ZERO_OFS + 8'd8);
         push_char(ch);
         push_char(8'($urandom_range(0, 255)));
         return;
      end
      len = $urandom_range(1, 8);
      push_char(CHAR_ZERO_OFS + 8'(len));
      for (int b = 0; b < 2 * len; b++) begin
         if ($urandom_range(0, 4) == 0) push_char(8'($urandom_range(0, 255)));
         else push_char(hex_char(4'($urandom_range(0, 15)), 1'b1));
      end

      if (sched) begin
         if (shape >= 93) begin
            send_text("0000");
            push_char(8'($urandom_range(0, 255)));
            return;
         end
         any_nonzero = 1'b0;
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 9) < 7) ch = CHAR_ZERO_OFS + 8'($urandom_range(0, 9));
            else ch = 8'($urandom_range(0, 255));
            // keep the period nonzero on the last digit if needed
            if (k == 3 && !any_nonzero && ch == CHAR_ZERO_OFS)
               ch = CHAR_ZERO_OFS + 8'($urandom_range(1, 9));
            if (ch != CHAR_ZERO_OFS) any_nonzero = 1'b1;
            push_char(ch);
         end
      end
      push_char(8'($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin : sink_pacing
      int roll;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (sink_calm > 0) begin
         rsp_chan.ready <= 1'b1;
         sink_calm--;
      end else if (sink_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         sink_stall--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            rsp_chan.ready <= 1'b1;
            sink_calm = $urandom_range(30, 100);
         end else if (roll < 80) begin
            rsp_chan.ready <= 1'b1;
         end else if (roll < 95) begin
            rsp_chan.ready <= 1'b0;
            sink_stall = $urandom_range(0, 2);
         end else begin
            rsp_chan.ready <= 1'b0;
            sink_stall = $urandom_range(10, 40);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_char = 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // send once: ident at its limit, byte from mixed-case digits
      send_text("18001Ff");
      push_char(8'h00);
      // ident over the limit, lower and upper case hex, then recovery
      send_text("2a0A");
      push_char(8'hFF);
      send_text("2801");
      push_char(8'h30);
      // non-hex digits count as zero; period from wrapped non-digits, truncated
      send_text("21231g0");
      repeat (4) push_char(8'hFF);
      push_char(8'h7F);

      while (chars_sent < CHAR_TARGET) send_frame_request();
      req_chan.valid <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
